/* src/ifp_pkg.sv */
// Shared constants and types of the IMU frame parser.
`timescale 1ns / 1ps
package ifp_pkg;

  localparam int BUFFER_BYTES_DEFAULT = 64;
  localparam int FRAME_BYTES = 28;
  localparam int QUEUE_DEPTH = 2;
  localparam int PRESSURE_BYTE = 24;

  localparam logic [7:0] SYNC_FIRST = 8'h88;
  localparam logic [7:0] SYNC_SECOND = 8'hAF;
  localparam logic [3:0] LAST_FIELD = 4'd12;

  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;
  typedef logic [3:0] field_idx_t;

endpackage

/* src/imu_frame_parser_top.sv */
// Top level of the IMU frame parser.
//
//   Channel   Handshake     Payload
//   request   push / full   rx_byte_i
//   result    pop / empty   field_index_o, field_value_o, last_field_o
//
// One received byte is taken per cycle while full is low.
// A good checksum byte queues the frame; the emitter then gives one field per
// cycle while pop is high, thirteen per frame, from its output register.
// Full is high only while a checksum byte is due and both frame queue entries wait.
// Reset clears the parser state, the payload bytes, the frame queue and the emitter state at once.
`timescale 1ns / 1ps
module imu_frame_parser_top #(
  parameter int BUFFER_BYTES = ifp_pkg::BUFFER_BYTES_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          rx_byte_i,
  input  logic                push,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output ifp_pkg::field_idx_t field_index_o,
  output logic signed [31:0]  field_value_o,
  output logic                last_field_o
);
  import ifp_pkg::*;

  logic   good_frame;
  frame_t front_frame;
  logic   queue_full;
  logic   queue_valid;
  frame_t queue_frame;
  logic   frame_done;

  ifp_front #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_byte_i    (rx_byte_i),
    .push         (push),
    .full         (full),
    .frame_valid_o(good_frame),
    .frame_o      (front_frame),
    .queue_full_i (queue_full)
  );

  ifp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (good_frame),
    .wr_frame_i(front_frame),
    .full_o    (queue_full),
    .valid_o   (queue_valid),
    .rd_frame_o(queue_frame),
    .rd_en_i   (frame_done)
  );

  ifp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_valid_i(queue_valid),
    .frame_i      (queue_frame),
    .frame_done_o (frame_done),
    .empty        (empty),
    .pop          (pop),
    .field_index_o(field_index_o),
    .field_value_o(field_value_o),
    .last_field_o (last_field_o)
  );

endmodule

/* src/ifp_front.sv */
// Byte parser: sync hunt, length check, payload capture and checksum test.
`timescale 1ns / 1ps
module ifp_front #(
  parameter int BUFFER_BYTES = ifp_pkg::BUFFER_BYTES_DEFAULT
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      rx_byte_i,
  input  logic            push,
  output logic            full,
  output logic            frame_valid_o,
  output ifp_pkg::frame_t frame_o,
  input  logic            queue_full_i
);
  import ifp_pkg::*;

  typedef enum logic [2:0] {
    PhHunt,
    PhSync,
    PhLen,
    PhData,
    PhCheck
  } phase_e;

  localparam logic [8:0] LenLimit = 9'(BUFFER_BYTES);

  phase_e     phase_q, phase_d;
  logic [7:0] len_q, len_d;
  logic [7:0] count_q, count_d;
  logic [7:0] sum_q, sum_d;
  frame_t     store_q;
  logic       accept;
  logic [8:0] count_next;

  assign full = (phase_q == PhCheck) && queue_full_i;
  assign accept = push && !full;
  assign count_next = {1'b0, count_q} + 9'd1;
  assign frame_o = store_q;

  always_comb begin
    phase_d = phase_q;
    len_d = len_q;
    count_d = count_q;
    sum_d = sum_q;
    frame_valid_o = 1'b0;
    if (accept) begin
      unique case (phase_q)
        PhSync: begin
          if (rx_byte_i == SYNC_SECOND) begin
            sum_d = sum_q + SYNC_SECOND;
            phase_d = PhLen;
          end
        end
        PhLen: begin
          count_d = '0;
          if (rx_byte_i == 8'd0 || {1'b0, rx_byte_i} > LenLimit) begin
            phase_d = PhHunt;
          end else begin
            len_d = rx_byte_i;
            sum_d = sum_q + rx_byte_i;
            phase_d = PhData;
          end
        end
        PhData: begin
          sum_d = sum_q + rx_byte_i;
          count_d = count_next[7:0];
          if (count_next >= {1'b0, len_q}) begin
            phase_d = PhCheck;
          end
        end
        PhCheck: begin
          frame_valid_o = (rx_byte_i == sum_q);
          phase_d = PhHunt;
        end
        default: begin
          if (rx_byte_i == SYNC_FIRST) begin
            sum_d = SYNC_FIRST;
            phase_d = PhSync;
          end else begin
            phase_d = PhHunt;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      len_q <= '0;
      count_q <= '0;
      sum_q <= '0;
    end else begin
      phase_q <= phase_d;
      len_q <= len_d;
      count_q <= count_d;
      sum_q <= sum_d;
    end
  end

  // Only the first FRAME_BYTES bytes of the payload are ever decoded; later ones are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '0;
    end else if (accept && phase_q == PhData) begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
        if (count_q == 8'(i)) begin
          store_q[i] <= rx_byte_i;
        end
      end
    end
  end

endmodule

/* src/ifp_queue.sv */
// Short queue of checked frames between the parser and the field emitter.
`timescale 1ns / 1ps
module ifp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  ifp_pkg::frame_t wr_frame_i,
  output logic            full_o,
  output logic            valid_o,
  output ifp_pkg::frame_t rd_frame_o,
  input  logic            rd_en_i
);
  import ifp_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  frame_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_wr, do_rd;

  assign full_o = (count_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign do_wr = wr_en_i && !full_o;
  assign do_rd = rd_en_i && valid_o;
  assign rd_frame_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_frame_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* src/ifp_back.sv */
// Field emitter: decodes one queued frame into its thirteen fields.
`timescale 1ns / 1ps
module ifp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               frame_valid_i,
  input  ifp_pkg::frame_t    frame_i,
  output logic               frame_done_o,
  output logic               empty,
  input  logic               pop,
  output ifp_pkg::field_idx_t field_index_o,
  output logic signed [31:0] field_value_o,
  output logic               last_field_o
);
  import ifp_pkg::*;

  field_idx_t         idx_q;
  logic               out_valid_q;
  field_idx_t         out_index_q;
  logic signed [31:0] out_value_q;
  logic               out_last_q;
  logic               load;
  logic [4:0]         hi_pos;
  logic [4:0]         lo_pos;
  logic [31:0]        value;

  assign load = frame_valid_i && (!out_valid_q || pop);
  assign frame_done_o = load && (idx_q == LAST_FIELD);
  assign hi_pos = {idx_q, 1'b0};
  assign lo_pos = {idx_q, 1'b1};

  always_comb begin
    if (idx_q == LAST_FIELD) begin
      value = {frame_i[PRESSURE_BYTE + 3], frame_i[PRESSURE_BYTE + 2],
               frame_i[PRESSURE_BYTE + 1], frame_i[PRESSURE_BYTE]};
    end else begin
      value = {{16{frame_i[hi_pos][7]}}, frame_i[hi_pos], frame_i[lo_pos]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q <= (idx_q == LAST_FIELD) ? '0 : idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_index_q <= idx_q;
      out_value_q <= signed'(value);
      out_last_q <= (idx_q == LAST_FIELD);
    end
  end

  assign empty = !out_valid_q;
  assign field_index_o = out_index_q;
  assign field_value_o = out_value_q;
  assign last_field_o = out_last_q;

endmodule

/* tb/imu_frame_parser_top_test.sv */
// Self-checking testbench of the IMU frame parser: byte stream in, decoded fields out.
`timescale 1ns / 1ps
module imu_frame_parser_top_test;
  import ifp_pkg::*;

  localparam int STORE_BYTES = BUFFER_BYTES_DEFAULT;
  localparam int FIELDS_PER_FRAME = 13;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int CALM_TAIL_BYTES = 60;
  localparam int RANDOM_BYTES = 20;
  localparam int KEEP_RANDOM = -1;
  localparam int KEEP_EXTREMES = -2;

  typedef enum logic [2:0] {
    HUNT_FIRST,
    WAIT_SECOND,
    READ_LENGTH,
    READ_PAYLOAD,
    READ_CHECKSUM
  } parse_phase_e;

  typedef struct {
    logic [7:0] data;
    bit         wait_idle;
    bit         hold_reader;
  } pending_byte_t;

  typedef struct {
    field_idx_t         index;
    logic signed [31:0] value;
    logic               last;
  } decoded_field_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic [7:0]         rx_byte = 8'h00;
  logic               push = 1'b0;
  logic               full;
  logic               empty;
  logic               pop = 1'b0;
  field_idx_t         field_index;
  logic signed [31:0] field_value;
  logic               last_field;

  pending_byte_t  byte_queue[$];
  decoded_field_t expected_fields[$];
  pending_byte_t  next_byte;
  decoded_field_t oldest_field;

  parse_phase_e phase = HUNT_FIRST;
  int           frame_len = 0;
  int           payload_count = 0;
  logic [7:0]   checksum_acc = 8'h00;
  logic [7:0]   payload_bytes [STORE_BYTES];

  int error_count = 0;
  int send_gap = 0;
  int read_gap = 0;
  int hold_left = 0;
  bit hold_request = 1'b0;
  bit calm;

  imu_frame_parser_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_byte_i    (rx_byte),
    .push         (push),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .field_index_o(field_index),
    .field_value_o(field_value),
    .last_field_o (last_field)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  assign calm = byte_queue.size() < CALM_TAIL_BYTES;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    error_count++;
  endtask

  task automatic queue_decoded_frame();
    logic [7:0] hi;
    logic [7:0] lo;
    decoded_field_t f;
    for (int k = 0; k < FIELDS_PER_FRAME - 1; k++) begin
      hi = payload_bytes[2 * k];
      lo = payload_bytes[2 * k + 1];
      f.index = field_idx_t'(k);
      f.value = {{16{hi[7]}}, hi, lo};
      f.last = 1'b0;
      expected_fields.push_back(f);
    end
    f.index = LAST_FIELD;
    f.value = {payload_bytes[PRESSURE_BYTE + 3], payload_bytes[PRESSURE_BYTE + 2],
               payload_bytes[PRESSURE_BYTE + 1], payload_bytes[PRESSURE_BYTE]};
    f.last = 1'b1;
    expected_fields.push_back(f);
  endtask

  task automatic parse_byte(input logic [7:0] b);
    case (phase)
      WAIT_SECOND: begin
        if (b == SYNC_SECOND) begin
          checksum_acc = checksum_acc + SYNC_SECOND;
          phase = READ_LENGTH;
        end
      end
      READ_LENGTH: begin
        payload_count = 0;
        if (b == 8'd0 || int'(b) > STORE_BYTES) begin
          phase = HUNT_FIRST;
        end else begin
          frame_len = int'(b);
          checksum_acc = checksum_acc + b;
          phase = READ_PAYLOAD;
        end
      end
      READ_PAYLOAD: begin
        if (payload_count < STORE_BYTES) payload_bytes[payload_count] = b;
        checksum_acc = checksum_acc + b;
        payload_count++;
        if (payload_count >= frame_len) phase = READ_CHECKSUM;
      end
      READ_CHECKSUM: begin
        if (b == checksum_acc) queue_decoded_frame();
        phase = HUNT_FIRST;
      end
      default: begin
        if (b == SYNC_FIRST) begin
          checksum_acc = SYNC_FIRST;
          phase = WAIT_SECOND;
        end else begin
          phase = HUNT_FIRST;
        end
      end
    endcase
  endtask

  task automatic add_byte(input logic [7:0] data, input bit wait_idle = 1'b0,
                          input bit hold_reader = 1'b0);
    pending_byte_t p;
    p.data = data;
    p.wait_idle = wait_idle;
    p.hold_reader = hold_reader;
    byte_queue.push_back(p);
  endtask

  task automatic add_noise(input int count);
    for (int i = 0; i < count; i++) add_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic add_bad_length(input logic [7:0] len);
    add_byte(SYNC_FIRST);
    add_byte(SYNC_SECOND);
    add_byte(len);
  endtask

  // A fill of KEEP_RANDOM gives random payload, KEEP_EXTREMES the 7F FF 80 00 pattern.
  task automatic add_frame(input int len, input int fill = KEEP_RANDOM,
                           input bit bad_sum = 1'b0, input int sync_noise = 0,
                           input bit wait_idle = 1'b0, input bit hold_reader = 1'b0);
    logic [7:0] sum;
    logic [7:0] b;
    add_byte(SYNC_FIRST, wait_idle, hold_reader);
    for (int i = 0; i < sync_noise; i++) begin
      b = (i == 0) ? SYNC_FIRST : 8'($urandom_range(0, 254));
      if (i != 0 && b >= SYNC_SECOND) b = b + 8'd1;
      add_byte(b);
    end
    add_byte(SYNC_SECOND);
    add_byte(8'(len));
    sum = SYNC_FIRST + SYNC_SECOND + 8'(len);
    for (int i = 0; i < len; i++) begin
      if (fill == KEEP_RANDOM) b = 8'($urandom_range(0, 255));
      else if (fill == KEEP_EXTREMES) b = (i % 4 == 0) ? 8'h7F : (i % 4 == 1) ? 8'hFF :
                                          (i % 4 == 2) ? 8'h80 : 8'h00;
      else b = 8'(fill);
      sum = sum + b;
      add_byte(b);
    end
    if (bad_sum) sum = sum + 8'($urandom_range(1, 255));
    add_byte(sum);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) parse_byte(rx_byte);
      if (!push || !full) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (byte_queue.size() == 0) begin
          push <= 1'b0;
        end else if (byte_queue[0].wait_idle && expected_fields.size() != 0) begin
          push <= 1'b0;
        end else if (!calm && hold_left == 0 && $urandom_range(0, 15) == 0) begin
          send_gap = $urandom_range(1, 19) - 1;
          push <= 1'b0;
        end else begin
          next_byte = byte_queue.pop_front();
          rx_byte <= next_byte.data;
          push <= 1'b1;
          if (next_byte.hold_reader) hold_request = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_fields.size() == 0) begin
          report_mismatch($sformatf("field %0d value %0d with nothing expected",
                                    field_index, field_value));
        end else begin
          oldest_field = expected_fields.pop_front();
          if (field_index !== oldest_field.index)
            report_mismatch($sformatf("index %0d, expected %0d", field_index,
                                      oldest_field.index));
          if (field_value !== oldest_field.value)
            report_mismatch($sformatf("field %0d value %0d, expected %0d", oldest_field.index,
                                      field_value, oldest_field.value));
          if (last_field !== oldest_field.last)
            report_mismatch($sformatf("field %0d last flag %b, expected %b",
                                      oldest_field.index, last_field, oldest_field.last));
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (read_gap > 0) begin
        read_gap--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        read_gap = $urandom_range(1, 19) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    int random_bytes;
    int pick;
    int len;
    foreach (payload_bytes[i]) payload_bytes[i] = 8'h00;

    add_frame(2);
    add_frame(FRAME_BYTES, KEEP_EXTREMES);
    add_frame(FRAME_BYTES, KEEP_RANDOM, 1'b0, 3);
    add_bad_length(8'd0);
    add_bad_length(8'(STORE_BYTES + 1));
    add_bad_length(8'hFF);
    add_frame(1);
    add_frame(STORE_BYTES);
    add_frame(12, KEEP_RANDOM, 1'b1);
    add_frame(10);
    add_byte(SYNC_SECOND);
    add_byte(8'h00);
    add_byte(8'hFF);

    random_bytes = byte_queue.size();
    while (byte_queue.size() - random_bytes < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(29, STORE_BYTES)
                                         : $urandom_range(1, FRAME_BYTES);
      if (pick < 60) add_frame(len, KEEP_RANDOM, 1'b0, ($urandom_range(0, 9) == 0) ? 2 : 0);
      else if (pick < 72) add_frame(len, KEEP_RANDOM, 1'b1);
      else if (pick < 80) add_bad_length(($urandom_range(0, 1) == 0) ? 8'd0
                                         : 8'($urandom_range(STORE_BYTES + 1, 255)));
      else if (pick < 90) add_noise($urandom_range(1, 8));
      else begin
        add_bad_length(8'(len));
        add_noise($urandom_range(0, len));
      end
    end

    // The reader stalls while frames keep coming, so the block fills and backs up.
    add_frame(1, KEEP_RANDOM, 1'b0, 0, 1'b1, 1'b1);
    for (int i = 0; i < 6; i++) add_frame($urandom_range(1, 3));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (byte_queue.size() != 0 || push) @(posedge clk_i);
    while (expected_fields.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

endmodule
